// File: src/olsd_pkg.sv
// shared types, codes and constants of the open-loop sine duty generator
`default_nettype none

package olsd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd3;

    localparam logic [15:0] SUPPLY_RST = 16'd12000;
    localparam logic [15:0] LIMIT_RST  = 16'd1200;
    localparam logic [6:0]  POLES_RST  = 7'd7;
    localparam logic        MODE_RST   = 1'b0;

    // command codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_STEP  = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    // outcome codes
    localparam logic [2:0] OUTC_IDLE       = 3'd0;
    localparam logic [2:0] OUTC_WRITTEN    = 3'd1;
    localparam logic [2:0] OUTC_STOPPED    = 3'd2;
    localparam logic [2:0] OUTC_FAULT_STOP = 3'd3;
    localparam logic [2:0] OUTC_STARTED    = 3'd4;
    localparam logic [2:0] OUTC_REFUSED    = 3'd5;

    // fixed-point constants
    localparam int          AMP_W       = 15;
    localparam logic [31:0] PHASE_GAIN  = 32'd2867080570;
    localparam logic [62:0] ROUND_Q30   = 63'd536870912;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [AMP_W-1:0] AMP_MAX = 15'd29491;
    localparam logic [31:0] THIRD_TURN  = 32'd1431655765;
    localparam logic [31:0] ROUND_Q16   = 32'd32768;
    localparam logic [17:0] DUTY_HALF   = 18'd32768;
    localparam logic [17:0] DUTY_FULL   = 18'd65536;

    typedef logic [16:0] duty_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_PP,
        ST_MUL_EL,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ADV,
        ST_AMP_WAIT,
        ST_IDX,
        ST_ROM,
        ST_SCALE,
        ST_DUTY,
        ST_OUT
    } state_t;

    // status of the amplitude divider
    typedef struct packed {
        logic             busy;
        logic [AMP_W-1:0] amp;
    } amp_stat_t;

    typedef struct packed {
        duty_t      duty_a;
        duty_t      duty_b;
        duty_t      duty_c;
        logic [2:0] outcome;
        logic       active;
    } result_t;

endpackage

`default_nettype wire

// File: src/olsd_if.sv
// command and result channel interfaces
`default_nettype none

interface olsd_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [31:0]        time_now_us;
    logic signed [23:0] speed_q16_8;
    logic               pwm_is_on;
    logic               gate_is_on;
    logic               fault_present;

    modport source (
        output valid, func, time_now_us, speed_q16_8, pwm_is_on, gate_is_on, fault_present,
        input  ready
    );
    modport sink (
        input  valid, func, time_now_us, speed_q16_8, pwm_is_on, gate_is_on, fault_present,
        output ready
    );
endinterface

interface olsd_res_if;
    logic        valid;
    logic        ready;
    logic [16:0] duty_phase_a;
    logic [16:0] duty_phase_b;
    logic [16:0] duty_phase_c;
    logic [2:0]  outcome;
    logic        output_active;

    modport source (
        output valid, duty_phase_a, duty_phase_b, duty_phase_c, outcome, output_active,
        input  ready
    );
    modport sink (
        input  valid, duty_phase_a, duty_phase_b, duty_phase_c, outcome, output_active,
        output ready
    );
endinterface

`default_nettype wire

// File: src/open_loop_three_phase_sine_duty_top.sv
// open-loop three-phase sine duty generator, top level
//
// channels: cmd (sink) carries one command beat: start, step or stop with a
// microsecond timestamp, signed q16.8 mechanical speed and three status flags.
// res (source) returns exactly one beat per command: three q1.16 duties, an
// outcome code and the output-active flag. cfg_we/cfg_index/cfg_data write
// the four configuration registers, one per cycle; the user must write them
// only while the block is idle, which the block itself does not enforce.
// start, stop and a step while stopped go from idle straight to the output
// state. for a running step a shared 32x32 multiplier is used ten times in
// sequence (phase advance, then index and scaling for each phase) and the
// sine table has a single read port. cmd.ready is high only in the idle
// state, so a new command is taken only once the last result has been
// registered. the amplitude divider runs after reset and after any write
// of the supply or limit register; a step waits for it before its first
// duty. reset: angle and timestamp zero, generator stopped, registers at
// defaults. a stalled receiver holds the result beat; the block keeps the
// next result until the pending beat has been taken.
`default_nettype none

module open_loop_three_phase_sine_duty_top #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int MAX_STEP_US      = 100000
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [olsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [olsd_pkg::CFG_DATA_W-1:0]   cfg_data,
    olsd_cmd_if.sink                          cmd,
    olsd_res_if.source                        res
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int EL_W  = $clog2(MAX_STEP_US + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SINE_TABLE_DEPTH - 1);

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    olsd_pkg::state_t state_reg;
    olsd_pkg::state_t state_next;

    // configuration
    logic [15:0] supply_reg;
    logic [15:0] limit_reg;
    logic [6:0]  poles_reg;
    logic        mode_reg;
    logic        amp_dirty_reg;

    // generator state
    logic [31:0] phase_reg;
    logic [31:0] last_reg;
    logic        running_reg;

    // per-item working registers
    logic [31:0]       now_reg;
    logic [23:0]       mag_reg;
    logic              neg_reg;
    logic [EL_W-1:0]   elapsed_reg;
    logic              chk_ok_reg;
    logic              fault_reg;
    logic [31:0]       ph_reg;
    logic [31:0]       rnd_reg;
    logic [1:0]        quarter_reg;
    logic [1:0]        k_reg;
    olsd_pkg::duty_t   duty_reg [3];
    logic [2:0]        outc_reg;
    logic              active_reg;

    // output stage
    logic               out_valid_reg;
    olsd_pkg::result_t  out_reg;

    // ---------------------------------------------------------------
    // shared units
    // ---------------------------------------------------------------
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         prod;
    logic [IDX_W-1:0]    rom_addr;
    logic [15:0]         rom_data;
    logic                div_start;
    olsd_pkg::amp_stat_t amp_stat;

    olsd_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    olsd_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    olsd_amp_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .limit  (limit_reg),
        .supply (supply_reg),
        .stat   (amp_stat)
    );

    // rerun the divider once it is free whenever supply or limit changed
    assign div_start = amp_dirty_reg && !amp_stat.busy;

    // ---------------------------------------------------------------
    // input decode
    // ---------------------------------------------------------------
    logic            cmd_fire;
    logic            out_free;
    logic            gate_ok_in;
    logic            chk_ok_in;
    logic            start_ok_in;
    logic [23:0]     speed_u;
    logic [23:0]     mag_in;
    logic [31:0]     elapsed_raw;
    logic [EL_W-1:0] elapsed_in;

    assign cmd.ready = (state_reg == olsd_pkg::ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || res.ready;

    always_comb
    begin
        gate_ok_in  = mode_reg ? cmd.gate_is_on : !cmd.gate_is_on;
        chk_ok_in   = cmd.pwm_is_on && gate_ok_in;
        start_ok_in = chk_ok_in && !cmd.fault_present;
        speed_u     = cmd.speed_q16_8;
        // magnitude of the most negative speed stays 2^23
        mag_in      = speed_u[23] ? (24'd0 - speed_u) : speed_u;
        elapsed_raw = cmd.time_now_us - last_reg;
        elapsed_in  = (elapsed_raw > 32'(MAX_STEP_US)) ?
                      EL_W'(MAX_STEP_US) : elapsed_raw[EL_W-1:0];
    end

    // ---------------------------------------------------------------
    // phase advance and duty arithmetic
    // ---------------------------------------------------------------
    logic [62:0]      rnd_sum;
    logic [31:0]      inc;
    logic [31:0]      phase_next;
    logic [31:0]      angle_k;
    logic [IDX_W-1:0] idx_raw;
    logic [IDX_W-1:0] idx_clamp;
    logic [31:0]      scaled_sum;
    logic [17:0]      m_val;
    logic [17:0]      duty_wide;
    olsd_pkg::duty_t  duty_val;

    always_comb
    begin
        // low half of the phase product, rounded into the q30 turn scale
        rnd_sum    = {1'b0, prod[61:0]} + olsd_pkg::ROUND_Q30;
        inc        = prod[31:0] + rnd_reg;
        phase_next = neg_reg ? (phase_reg - inc) : (phase_reg + inc);

        case (k_reg)
            2'd1:    angle_k = phase_reg - olsd_pkg::THIRD_TURN;
            2'd2:    angle_k = phase_reg + olsd_pkg::THIRD_TURN;
            default: angle_k = phase_reg;
        endcase

        // table index from the in-quarter fraction, mirrored in odd quarters
        idx_raw   = prod[30 +: IDX_W];
        idx_clamp = (idx_raw > IDX_LAST) ? IDX_LAST : idx_raw;
        rom_addr  = quarter_reg[0] ? (IDX_LAST - idx_clamp) : idx_clamp;

        scaled_sum = prod[31:0] + olsd_pkg::ROUND_Q16;
        m_val      = {2'b00, scaled_sum[31:16]};
        if (quarter_reg[1])
        begin
            duty_wide = (m_val > olsd_pkg::DUTY_HALF) ? '0 : (olsd_pkg::DUTY_HALF - m_val);
        end
        else
        begin
            duty_wide = olsd_pkg::DUTY_HALF + m_val;
        end
        duty_val = (duty_wide > olsd_pkg::DUTY_FULL) ?
                   olsd_pkg::DUTY_FULL[16:0] : duty_wide[16:0];
    end

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            olsd_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.func == olsd_pkg::FUNC_STEP && running_reg)
                    begin
                        state_next = olsd_pkg::ST_MUL_PP;
                    end
                    else
                    begin
                        state_next = olsd_pkg::ST_OUT;
                    end
                end
            end
            olsd_pkg::ST_MUL_PP: state_next = olsd_pkg::ST_MUL_EL;
            olsd_pkg::ST_MUL_EL: state_next = olsd_pkg::ST_MUL_LO;
            olsd_pkg::ST_MUL_LO: state_next = olsd_pkg::ST_MUL_HI;
            olsd_pkg::ST_MUL_HI: state_next = olsd_pkg::ST_ADV;
            olsd_pkg::ST_ADV:
            begin
                state_next = chk_ok_reg ? olsd_pkg::ST_AMP_WAIT : olsd_pkg::ST_OUT;
            end
            olsd_pkg::ST_AMP_WAIT:
            begin
                if (!amp_stat.busy && !amp_dirty_reg)
                begin
                    state_next = olsd_pkg::ST_IDX;
                end
            end
            olsd_pkg::ST_IDX:   state_next = olsd_pkg::ST_ROM;
            olsd_pkg::ST_ROM:   state_next = olsd_pkg::ST_SCALE;
            olsd_pkg::ST_SCALE: state_next = olsd_pkg::ST_DUTY;
            olsd_pkg::ST_DUTY:
            begin
                state_next = (k_reg == 2'd2) ? olsd_pkg::ST_OUT : olsd_pkg::ST_IDX;
            end
            olsd_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = olsd_pkg::ST_IDLE;
                end
            end
            default: state_next = olsd_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: multiplier operands per state
    // ---------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            olsd_pkg::ST_MUL_PP:
            begin
                // |speed| * pole pairs
                mul_a = 32'(mag_reg);
                mul_b = 32'(poles_reg);
            end
            olsd_pkg::ST_MUL_EL:
            begin
                // times elapsed microseconds
                mul_a = prod[31:0];
                mul_b = 32'(elapsed_reg);
            end
            olsd_pkg::ST_MUL_LO:
            begin
                mul_a = {2'b00, prod[29:0]};
                mul_b = olsd_pkg::PHASE_GAIN;
            end
            olsd_pkg::ST_MUL_HI:
            begin
                mul_a = ph_reg;
                mul_b = olsd_pkg::PHASE_GAIN;
            end
            olsd_pkg::ST_IDX:
            begin
                mul_a = {2'b00, angle_k[29:0]};
                mul_b = 32'(SINE_TABLE_DEPTH);
            end
            olsd_pkg::ST_SCALE:
            begin
                mul_a = 32'(amp_stat.amp);
                mul_b = 32'(rom_data);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // control and generator state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= olsd_pkg::ST_IDLE;
            supply_reg    <= olsd_pkg::SUPPLY_RST;
            limit_reg     <= olsd_pkg::LIMIT_RST;
            poles_reg     <= olsd_pkg::POLES_RST;
            mode_reg      <= olsd_pkg::MODE_RST;
            amp_dirty_reg <= 1'b1;
            phase_reg     <= '0;
            last_reg      <= '0;
            running_reg   <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    olsd_pkg::REG_SUPPLY: supply_reg <= cfg_data;
                    olsd_pkg::REG_LIMIT:  limit_reg  <= cfg_data;
                    olsd_pkg::REG_POLES:  poles_reg  <= cfg_data[6:0];
                    olsd_pkg::REG_MODE:   mode_reg   <= cfg_data[0];
                    default:              mode_reg   <= mode_reg;
                endcase
            end

            // a write that lands with a divider start keeps the flag for a rerun
            if (cfg_we && (cfg_index == olsd_pkg::REG_SUPPLY ||
                           cfg_index == olsd_pkg::REG_LIMIT))
            begin
                amp_dirty_reg <= 1'b1;
            end
            else if (div_start)
            begin
                amp_dirty_reg <= 1'b0;
            end

            if (cmd_fire)
            begin
                k_reg <= '0;
                case (cmd.func)
                    olsd_pkg::FUNC_START:
                    begin
                        phase_reg   <= '0;
                        last_reg    <= cmd.time_now_us;
                        running_reg <= start_ok_in;
                    end
                    olsd_pkg::FUNC_STOP:
                    begin
                        running_reg <= 1'b0;
                    end
                    default:
                    begin
                        running_reg <= running_reg;
                    end
                endcase
            end

            if (state_reg == olsd_pkg::ST_ADV)
            begin
                phase_reg <= phase_next;
                if (!chk_ok_reg)
                begin
                    running_reg <= 1'b0;
                end
            end

            if (state_reg == olsd_pkg::ST_DUTY)
            begin
                k_reg <= k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    last_reg <= now_reg;
                    if (fault_reg)
                    begin
                        running_reg <= 1'b0;
                    end
                end
            end

            if (state_reg == olsd_pkg::ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // working and result payload
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            now_reg     <= cmd.time_now_us;
            mag_reg     <= mag_in;
            neg_reg     <= speed_u[23];
            elapsed_reg <= elapsed_in;
            chk_ok_reg  <= chk_ok_in;
            fault_reg   <= cmd.fault_present;
            duty_reg[0] <= '0;
            duty_reg[1] <= '0;
            duty_reg[2] <= '0;
            if (cmd.func == olsd_pkg::FUNC_START)
            begin
                outc_reg   <= start_ok_in ? olsd_pkg::OUTC_STARTED : olsd_pkg::OUTC_REFUSED;
                active_reg <= start_ok_in;
            end
            else
            begin
                outc_reg   <= olsd_pkg::OUTC_IDLE;
                active_reg <= 1'b0;
            end
        end

        if (state_reg == olsd_pkg::ST_MUL_LO)
        begin
            ph_reg <= prod[61:30];
        end

        if (state_reg == olsd_pkg::ST_MUL_HI)
        begin
            rnd_reg <= rnd_sum[61:30];
        end

        if (state_reg == olsd_pkg::ST_ADV && !chk_ok_reg)
        begin
            outc_reg <= olsd_pkg::OUTC_STOPPED;
        end

        if (state_reg == olsd_pkg::ST_IDX)
        begin
            quarter_reg <= angle_k[31:30];
        end

        if (state_reg == olsd_pkg::ST_DUTY)
        begin
            duty_reg[k_reg] <= duty_val;
            if (k_reg == 2'd2)
            begin
                outc_reg   <= fault_reg ? olsd_pkg::OUTC_FAULT_STOP : olsd_pkg::OUTC_WRITTEN;
                active_reg <= !fault_reg;
            end
        end

        if (state_reg == olsd_pkg::ST_OUT && out_free)
        begin
            out_reg.duty_a  <= duty_reg[0];
            out_reg.duty_b  <= duty_reg[1];
            out_reg.duty_c  <= duty_reg[2];
            out_reg.outcome <= outc_reg;
            out_reg.active  <= active_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.duty_phase_a  = out_reg.duty_a;
    assign res.duty_phase_b  = out_reg.duty_b;
    assign res.duty_phase_c  = out_reg.duty_c;
    assign res.outcome       = out_reg.outcome;
    assign res.output_active = out_reg.active;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // output admitted only after a good start or a clean step
    a_active_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.output_active == (res.outcome == olsd_pkg::OUTC_WRITTEN ||
                                             res.outcome == olsd_pkg::OUTC_STARTED)))
        else $error("output_active disagrees with outcome");

    // no duties reported unless this step wrote them
    a_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.outcome != olsd_pkg::OUTC_WRITTEN &&
         res.outcome != olsd_pkg::OUTC_FAULT_STOP)
        |-> (res.duty_phase_a == '0 && res.duty_phase_b == '0 && res.duty_phase_c == '0))
        else $error("nonzero duty without a written step");

    // amplitude settled while duties are formed
    a_amp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == olsd_pkg::ST_SCALE) |-> (!amp_stat.busy && !amp_dirty_reg))
        else $error("amplitude divider busy during duty scaling");

    // a failed check leaves the generator stopped
    a_check_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == olsd_pkg::ST_ADV && !chk_ok_reg) |=> !running_reg)
        else $error("generator still running after failed check");

endmodule

`default_nettype wire

// File: src/olsd_mul.sv
// shared 32x32 unsigned multiplier with registered product
`default_nettype none

module olsd_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a) * 64'(b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: src/olsd_amp_div.sv
// iterative amplitude divider: limit * 65536 / supply, clamped
`default_nettype none

module olsd_amp_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [15:0]         limit,
    input  logic [15:0]         supply,
    output olsd_pkg::amp_stat_t stat
);

    localparam int          STEPS = 16;
    localparam int          CNT_W = $clog2(STEPS + 1);

    logic                       busy_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [15:0]                r_reg;
    logic [15:0]                d_reg;
    logic [15:0]                q_reg;
    logic [olsd_pkg::AMP_W-1:0] amp_reg;

    logic [16:0] r2;
    logic        ge;
    logic [15:0] r_next;
    logic [15:0] q_next;

    // one restoring step a cycle
    always_comb
    begin
        r2     = {r_reg, 1'b0};
        ge     = (r2 >= {1'b0, d_reg});
        r_next = ge ? 16'(r2 - {1'b0, d_reg}) : r2[15:0];
        q_next = {q_reg[14:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            if (supply != 16'd0 && limit < supply)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= limit;
            d_reg <= supply;
            q_reg <= '0;
            if (supply == 16'd0)
            begin
                amp_reg <= (limit != 16'd0) ? olsd_pkg::AMP_MAX : '0;
            end
            else if (limit >= supply)
            begin
                amp_reg <= olsd_pkg::AMP_MAX;
            end
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            q_reg <= q_next;
            if (cnt_reg == CNT_W'(1))
            begin
                amp_reg <= (q_next > 16'(olsd_pkg::AMP_MAX)) ?
                           olsd_pkg::AMP_MAX : q_next[olsd_pkg::AMP_W-1:0];
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.amp  = amp_reg;

endmodule

`default_nettype wire

// File: src/olsd_sine_rom.sv
// quarter-wave sine table, contents built at elaboration, registered read
`default_nettype none

module olsd_sine_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    output logic [15:0]              data
);

    localparam logic [63:0] X_DIV = 64'(2 * DEPTH);
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    // two multiplications by x, each rescaled from q30
    function automatic logic [63:0] sq_step(input logic [63:0] t, input logic [63:0] xx);
        logic [63:0] u;
        u = (t * xx) >> 30;
        return (u * xx) >> 30;
    endfunction

    function automatic logic [15:0] sine_entry(input int unsigned i);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        s;
        logic [63:0]        v;
        x    = (64'(2 * i + 1) * olsd_pkg::HALF_PI_Q30) / X_DIV;
        sum  = signed'(x);
        term = x;
        term = sq_step(term, x) / 64'd6;
        sum  = sum - signed'(term);
        term = sq_step(term, x) / 64'd20;
        sum  = sum + signed'(term);
        term = sq_step(term, x) / 64'd42;
        sum  = sum - signed'(term);
        term = sq_step(term, x) / 64'd72;
        sum  = sum + signed'(term);
        term = sq_step(term, x) / 64'd110;
        sum  = sum - signed'(term);
        term = sq_step(term, x) / 64'd156;
        sum  = sum + signed'(term);
        term = sq_step(term, x) / 64'd210;
        sum  = sum - signed'(term);
        term = sq_step(term, x) / 64'd272;
        sum  = sum + signed'(term);
        term = sq_step(term, x) / 64'd342;
        sum  = sum - signed'(term);
        if (sum < 0)
        begin
            s = '0;
        end
        else if (sum > signed'(ONE_Q30))
        begin
            s = ONE_Q30;
        end
        else
        begin
            s = unsigned'(sum);
        end
        v = (s * 64'd65535 + 64'd536870912) >> 30;
        if (v > 64'd65535)
        begin
            v = 64'd65535;
        end
        return v[15:0];
    endfunction

    logic [15:0] rom_w [DEPTH];
    logic [15:0] data_reg;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_entry
        localparam logic [15:0] ENTRY = sine_entry(g);
        assign rom_w[g] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_w[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// File: dv/open_loop_three_phase_sine_duty_top_test.sv
// self-checking testbench of the open-loop three-phase sine duty generator
`timescale 1ns / 1ps

module open_loop_three_phase_sine_duty_top_test;

    // table depth and step clamp as built into the block by default
    localparam int ROM_DEPTH = 1024;
    localparam logic [31:0] STEP_CAP_US = 32'd100000;

    // own copies of the fixed-point constants, kept apart from the package
    localparam logic [63:0] SPEED_GAIN = 64'd2867080570;   // 2^54 / (2 pi 1e6)
    localparam logic [63:0] QUARTER_Q30 = 64'd1686629713;  // pi/2 in q30
    localparam logic [31:0] AMP_CAP = 32'd29491;           // 0.45 in q0.16
    localparam logic [31:0] ONE_THIRD = 32'd1431655765;    // 120 degrees

    // command code with no meaning, answered like a stop without its effect
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int DIR_N = 25;
    localparam int PHASES = 8;
    localparam int BEATS_PER_PHASE = 85;

    // one command beat as the sender sees it
    typedef struct packed {
        logic [1:0]         func;
        logic [31:0]        stamp;
        logic signed [23:0] speed;
        logic               pwm;
        logic               gate;
        logic               fault;
    } cmd_beat_t;

    // directed row: command, and the answer where it is obvious
    typedef struct packed {
        cmd_beat_t  c;
        logic       known;
        logic [2:0] outc;
        logic       act;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [olsd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [olsd_pkg::CFG_DATA_W-1:0] cfg_data;

    olsd_cmd_if cmd_ch ();
    olsd_res_if res_ch ();

    open_loop_three_phase_sine_duty_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // generator state as predicted
    logic [31:0] ang_acc;
    logic [31:0] stamp_us;
    logic        gen_on;

    // register copies
    logic [15:0] bus_mv;
    logic [15:0] lim_mv;
    logic [6:0]  poles;
    logic        stage_mode;

    // quarter-wave sine magnitudes, q0.16
    logic [15:0] sine_rom [ROM_DEPTH];

    // predicted result beats, oldest first
    olsd_pkg::result_t expected_beats [$];

    int fail_count = 0;
    int gap_cap = 7;       // longest sender gap, in cycles
    int stall_cap = 7;     // longest receiver stall, in cycles
    logic [31:0] now_us;   // running microsecond clock of the random part

    // directed beats, run at reset settings (mode 0: gate must be off)
    dir_row_t dir_rows [DIR_N] = '{
        // step and stop while stopped, then the unused code with every flag set
        {olsd_pkg::FUNC_STEP,  32'd0,        24'sd0,     1'b1, 1'b0, 1'b0, 1'b1,
         olsd_pkg::OUTC_IDLE,       1'b0},
        {olsd_pkg::FUNC_STOP,  32'd0,        24'sd0,     1'b1, 1'b0, 1'b0, 1'b1,
         olsd_pkg::OUTC_IDLE,       1'b0},
        {FUNC_UNUSED,          32'hFFFFFFFF, 24'h7FFFFF, 1'b1, 1'b1, 1'b1, 1'b1,
         olsd_pkg::OUTC_IDLE,       1'b0},
        // each refusal of a start: pwm off, gate wrong, fault, all flags set
        {olsd_pkg::FUNC_START, 32'd100,      24'sd0,     1'b0, 1'b0, 1'b0, 1'b1,
         olsd_pkg::OUTC_REFUSED,    1'b0},
        {olsd_pkg::FUNC_START, 32'd100,      24'sd0,     1'b1, 1'b1, 1'b0, 1'b1,
         olsd_pkg::OUTC_REFUSED,    1'b0},
        {olsd_pkg::FUNC_START, 32'd100,      24'sd0,     1'b1, 1'b0, 1'b1, 1'b1,
         olsd_pkg::OUTC_REFUSED,    1'b0},
        {olsd_pkg::FUNC_START, 32'd100,      24'sd0,     1'b1, 1'b1, 1'b1, 1'b1,
         olsd_pkg::OUTC_REFUSED,    1'b0},
        {olsd_pkg::FUNC_STEP,  32'd200,      24'sd0,     1'b1, 1'b0, 1'b0, 1'b1,
         olsd_pkg::OUTC_IDLE,       1'b0},
        // good start, then steps at zero, full positive and full negative speed
        {olsd_pkg::FUNC_START, 32'd1000,     24'sd0,     1'b1, 1'b0, 1'b0, 1'b1,
         olsd_pkg::OUTC_STARTED,    1'b1},
        {olsd_pkg::FUNC_STEP,  32'd1000,     24'sd0,     1'b1, 1'b0, 1'b0, 1'b0,
         olsd_pkg::OUTC_IDLE,       1'b0},
        {olsd_pkg::FUNC_STEP,  32'd1500,     24'h7FFFFF, 1'b1, 1'b0, 1'b0, 1'b0,
         olsd_pkg::OUTC_IDLE,       1'b0},
        {olsd_pkg::FUNC_STEP,  32'h00010000, 24'h800000, 1'b1, 1'b0, 1'b0, 1'b0,
         olsd_pkg::OUTC_IDLE,       1'b0},
        // huge elapsed time, clamped; then a wrap of the timestamp
        {olsd_pkg::FUNC_STEP,  32'hFFFFFFFF, 24'h7FFFFF, 1'b1, 1'b0, 1'b0, 1'b0,
         olsd_pkg::OUTC_IDLE,       1'b0},
        {olsd_pkg::FUNC_STEP,  32'h00000100, 24'sd256,   1'b1, 1'b0, 1'b0, 1'b0,
         olsd_pkg::OUTC_IDLE,       1'b0},
        // step check fails on pwm off, generator stays stopped
        {olsd_pkg::FUNC_STEP,  32'h00000200, 24'sd256,   1'b0, 1'b0, 1'b0, 1'b1,
         olsd_pkg::OUTC_STOPPED,    1'b0},
        {olsd_pkg::FUNC_STEP,  32'h00000300, 24'sd256,   1'b1, 1'b0, 1'b0, 1'b1,
         olsd_pkg::OUTC_IDLE,       1'b0},
        // step check fails on the gate flag
        {olsd_pkg::FUNC_START, 32'h00000400, 24'sd0,     1'b1, 1'b0, 1'b0, 1'b1,
         olsd_pkg::OUTC_STARTED,    1'b1},
        {olsd_pkg::FUNC_STEP,  32'h00000500, 24'sd5000,  1'b1, 1'b1, 1'b0, 1'b1,
         olsd_pkg::OUTC_STOPPED,    1'b0},
        // fault after the duties are written
        {olsd_pkg::FUNC_START, 32'h00000600, 24'sd0,     1'b1, 1'b0, 1'b0, 1'b1,
         olsd_pkg::OUTC_STARTED,    1'b1},
        {olsd_pkg::FUNC_STEP,  32'h00000700, -24'sd2560, 1'b1, 1'b0, 1'b1, 1'b0,
         olsd_pkg::OUTC_IDLE,       1'b0},
        {olsd_pkg::FUNC_STEP,  32'h00000800, 24'sd0,     1'b1, 1'b0, 1'b0, 1'b1,
         olsd_pkg::OUTC_IDLE,       1'b0},
        // stop while running
        {olsd_pkg::FUNC_START, 32'h00000900, 24'sd0,     1'b1, 1'b0, 1'b0, 1'b1,
         olsd_pkg::OUTC_STARTED,    1'b1},
        {olsd_pkg::FUNC_STOP,  32'h00000900, 24'sd0,     1'b1, 1'b0, 1'b0, 1'b1,
         olsd_pkg::OUTC_IDLE,       1'b0},
        {olsd_pkg::FUNC_STEP,  32'h00000A00, 24'sd0,     1'b1, 1'b0, 1'b0, 1'b1,
         olsd_pkg::OUTC_IDLE,       1'b0},
        // start just below the wrap, random part goes on from here
        {olsd_pkg::FUNC_START, 32'hFFFFFF00, 24'sd0,     1'b1, 1'b0, 1'b0, 1'b1,
         olsd_pkg::OUTC_STARTED,    1'b1}
    };

    // duty of one phase: table lookup by quarter, scaled by the amplitude
    function automatic olsd_pkg::duty_t duty_at(logic [31:0] amp, logic [31:0] ang);
        logic [63:0] idx;
        logic [63:0] m;
        logic [31:0] d;
        idx = (64'(ang[29:0]) * ROM_DEPTH) >> 30;
        if (idx >= ROM_DEPTH)
            idx = ROM_DEPTH - 1;
        // odd quarters run the table backwards
        if (ang[30])
            idx = ROM_DEPTH - 1 - idx;
        m = (64'(amp) * 64'(sine_rom[idx]) + 64'd32768) >> 16;
        // lower half-turn pulls the duty below one half
        if (ang[31])
            d = (m > 64'd32768) ? 32'd0 : 32'(64'd32768 - m);
        else
            d = 32'(64'd32768 + m);
        if (d > 32'd65536)
            d = 32'd65536;
        return olsd_pkg::duty_t'(d);
    endfunction

    // advances the generator by one command and gives its answer
    function automatic olsd_pkg::result_t commutate(cmd_beat_t c);
        olsd_pkg::result_t r;
        logic gate_ok;
        logic [23:0] raw;
        logic [23:0] mag;
        logic [31:0] elapsed;
        logic [63:0] prod, hi, lo, a, b, low;
        logic [31:0] inc;
        logic [31:0] amp;
        r = '0;
        gate_ok = stage_mode ? c.gate : !c.gate;
        case (c.func)
            olsd_pkg::FUNC_START:
            begin
                // angle and timestamp are cleared even on a refusal
                ang_acc = 32'd0;
                stamp_us = c.stamp;
                if (c.pwm && gate_ok && !c.fault)
                begin
                    gen_on = 1'b1;
                    r.outcome = olsd_pkg::OUTC_STARTED;
                    r.active = 1'b1;
                end
                else
                begin
                    gen_on = 1'b0;
                    r.outcome = olsd_pkg::OUTC_REFUSED;
                end
            end
            olsd_pkg::FUNC_STEP:
            begin
                if (gen_on)
                begin
                    elapsed = c.stamp - stamp_us;
                    if (elapsed > STEP_CAP_US)
                        elapsed = STEP_CAP_US;
                    raw = c.speed;
                    mag = raw[23] ? (~raw + 24'd1) : raw;
                    // increment in turn fraction, rounded, split to stay in 64 bits
                    prod = 64'(mag) * 64'(poles) * 64'(elapsed);
                    hi = prod >> 25;
                    lo = prod & 64'h1FFFFFF;
                    a = hi * SPEED_GAIN;
                    b = lo * SPEED_GAIN;
                    low = ((a & 64'd31) << 25) + b + (64'd1 << 29);
                    inc = 32'((a >> 5) + (low >> 30));
                    if (raw[23])
                        ang_acc = ang_acc - inc;
                    else
                        ang_acc = ang_acc + inc;
                    if (!c.pwm || !gate_ok)
                    begin
                        // angle has moved, timestamp kept
                        gen_on = 1'b0;
                        r.outcome = olsd_pkg::OUTC_STOPPED;
                    end
                    else
                    begin
                        if (bus_mv == 16'd0)
                            amp = (lim_mv != 16'd0) ? AMP_CAP : 32'd0;
                        else
                            amp = 32'((64'(lim_mv) << 16) / 64'(bus_mv));
                        if (amp > AMP_CAP)
                            amp = AMP_CAP;
                        r.duty_a = duty_at(amp, ang_acc);
                        r.duty_b = duty_at(amp, ang_acc - ONE_THIRD);
                        r.duty_c = duty_at(amp, ang_acc + ONE_THIRD);
                        stamp_us = c.stamp;
                        if (c.fault)
                        begin
                            gen_on = 1'b0;
                            r.outcome = olsd_pkg::OUTC_FAULT_STOP;
                        end
                        else
                        begin
                            r.outcome = olsd_pkg::OUTC_WRITTEN;
                            r.active = 1'b1;
                        end
                    end
                end
            end
            olsd_pkg::FUNC_STOP:
                gen_on = 1'b0;
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // one command beat: random gap first, then hold valid until ready
    task automatic send_beat(input cmd_beat_t c, input logic typed,
                             input olsd_pkg::result_t typed_res);
        int gap;
        olsd_pkg::result_t pred;
        gap = $urandom_range(0, gap_cap);
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.func          <= c.func;
        cmd_ch.time_now_us   <= c.stamp;
        cmd_ch.speed_q16_8   <= c.speed;
        cmd_ch.pwm_is_on     <= c.pwm;
        cmd_ch.gate_is_on    <= c.gate;
        cmd_ch.fault_present <= c.fault;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        // accepted at this edge: the predictor always runs to keep its state
        pred = commutate(c);
        expected_beats.push_back(typed ? typed_res : pred);
    endtask

    // sender goes quiet until every predicted beat has come back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_beats.size() != 0);
    endtask

    task automatic write_reg(input logic [olsd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            olsd_pkg::REG_SUPPLY: bus_mv = val;
            olsd_pkg::REG_LIMIT:  lim_mv = val;
            olsd_pkg::REG_POLES:  poles = val[6:0];
            olsd_pkg::REG_MODE:   stage_mode = val[0];
            default:              ;
        endcase
    endtask

    // receiver: random stall per beat, compares each beat with the oldest prediction
    initial
    begin : result_sink
        int stall;
        olsd_pkg::result_t got;
        olsd_pkg::result_t want;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, stall_cap);
            if (stall != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            got.duty_a  = res_ch.duty_phase_a;
            got.duty_b  = res_ch.duty_phase_b;
            got.duty_c  = res_ch.duty_phase_c;
            got.outcome = res_ch.outcome;
            got.active  = res_ch.output_active;
            if (expected_beats.size() == 0)
            begin
                $display("%0t: result beat with nothing pending, outcome %0d", $time,
                         got.outcome);
                fail_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                check_field("duty_phase_a", want.duty_a, got.duty_a);
                check_field("duty_phase_b", want.duty_b, got.duty_b);
                check_field("duty_phase_c", want.duty_c, got.duty_c);
                check_field("outcome", want.outcome, got.outcome);
                check_field("output_active", want.active, got.active);
            end
        end
    end

    // hard stop well beyond the slowest correct run
    initial
    begin
        #400000;
        $display("open_loop_three_phase_sine_duty_top_test: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [63:0] x, term, v;
        longint sum;
        dir_row_t row;
        olsd_pkg::result_t typed;
        cmd_beat_t c;
        logic [15:0] sup, lim;
        logic [6:0] pp;
        logic md;
        int pick;

        // quarter-wave table: taylor series in q30 at the centre of each slot
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            x = (64'(2 * i + 1) * QUARTER_Q30) / (64'd2 * ROM_DEPTH);
            term = x;
            sum = longint'(x);
            for (int k = 1; k <= 9; k++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    sum -= longint'(term);
                else
                    sum += longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > 64'sd1073741824)
                sum = 64'sd1073741824;
            v = (64'(sum) * 64'd65535 + (64'd1 << 29)) >> 30;
            if (v > 64'd65535)
                v = 64'd65535;
            sine_rom[i] = v[15:0];
        end

        // state and registers after reset
        ang_acc = 32'd0;
        stamp_us = 32'd0;
        gen_on = 1'b0;
        bus_mv = 16'd12000;
        lim_mv = 16'd1200;
        poles = 7'd7;
        stage_mode = 1'b0;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= olsd_pkg::REG_SUPPLY;
        cfg_data <= 16'd0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.func <= olsd_pkg::FUNC_STOP;
        cmd_ch.time_now_us <= 32'd0;
        cmd_ch.speed_q16_8 <= 24'sd0;
        cmd_ch.pwm_is_on <= 1'b0;
        cmd_ch.gate_is_on <= 1'b0;
        cmd_ch.fault_present <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at reset settings
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            typed = '0;
            typed.outcome = row.outc;
            typed.active = row.act;
            send_beat(row.c, row.known, typed);
        end
        now_us = dir_rows[DIR_N - 1].c.stamp;
        drain();

        // random part: one register setting per phase, extremes first
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    // amplitude far past the clamp, 64 pole pairs, gated stage
                    sup = 16'd1; lim = 16'hFFFF; pp = 7'd64; md = 1'b1;
                end
                1:
                begin
                    // zero amplitude: all duties at one half
                    sup = 16'hFFFF; lim = 16'd0; pp = 7'd1; md = 1'b0;
                end
                2:
                begin
                    // zero supply voltage and zero pole pairs
                    sup = 16'd0; lim = 16'd1000; pp = 7'd0; md = 1'b1;
                end
                3:
                begin
                    sup = 16'd0; lim = 16'd0; pp = 7'd127; md = 1'b0;
                end
                4:
                begin
                    sup = 16'($urandom_range(1, 65535)); lim = 16'($urandom);
                    pp = 7'($urandom_range(1, 64)); md = 1'($urandom);
                end
                5:
                begin
                    sup = 16'd24000; lim = 16'($urandom_range(0, 12000));
                    pp = 7'($urandom_range(1, 20)); md = 1'b1;
                end
                6:
                begin
                    sup = 16'($urandom); lim = 16'($urandom);
                    pp = 7'($urandom); md = 1'($urandom);
                end
                default:
                begin
                    sup = 16'd12000; lim = 16'd1200; pp = 7'd7; md = 1'b0;
                end
            endcase
            write_reg(olsd_pkg::REG_SUPPLY, sup);
            write_reg(olsd_pkg::REG_LIMIT, lim);
            write_reg(olsd_pkg::REG_POLES, {9'd0, pp});
            write_reg(olsd_pkg::REG_MODE, {15'd0, md});
            cfg_we <= 1'b0;

            // every third phase runs without any gaps or stalls
            gap_cap = (p % 3 == 2) ? 0 : 7;
            stall_cap = (p % 3 == 2) ? 0 : 7;

            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                // one mid-phase pause with the sender holding off until all is back
                if (p == 4 && n == 40)
                    drain();

                // mostly well-formed: start when stopped, then a run of steps
                pick = $urandom_range(0, 99);
                if ((!gen_on && pick < 75) || pick < 3)
                    c.func = olsd_pkg::FUNC_START;
                else if (pick < 6)
                    c.func = olsd_pkg::FUNC_STOP;
                else if (pick < 8)
                    c.func = FUNC_UNUSED;
                else
                    c.func = olsd_pkg::FUNC_STEP;

                // flags right for the stage mode, with the odd fault or broken set
                c.pwm = 1'b1;
                c.gate = stage_mode;
                c.fault = 1'b0;
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    c.fault = 1'b1;
                else if (pick < 9)
                begin
                    c.pwm = 1'($urandom);
                    c.gate = 1'($urandom);
                    c.fault = 1'($urandom);
                end

                // speed: mostly moderate, some full-range and both extremes
                case ($urandom_range(0, 9))
                    0:       c.speed = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                    1, 2, 3: c.speed = 24'($urandom);
                    default: c.speed = 24'(int'($urandom_range(0, 40000)) - 20000);
                endcase

                // timestamp: short hops, some beyond the clamp, repeats and jumps
                case ($urandom_range(0, 19))
                    0:       now_us = $urandom;
                    1, 2:    now_us = now_us + $urandom_range(100000, 300000);
                    3:       ;
                    default: now_us = now_us + $urandom_range(1, 3000);
                endcase
                c.stamp = now_us;

                send_beat(c, 1'b0, '0);
            end
            drain();
        end

        // results are all in; let the block settle before the verdict
        repeat (40) @(posedge clk);
        if (fail_count == 0 && expected_beats.size() == 0)
            $display("open_loop_three_phase_sine_duty_top_test: PASS");
        else
            $display("open_loop_three_phase_sine_duty_top_test: FAIL");
        $finish;
    end

endmodule
